### src/v3alu_pkg.sv
package v3alu_pkg;

	localparam int unsigned FRAC_BITS_DEF  = 16;
	localparam int unsigned WORD_WIDTH_DEF = 32;
	localparam int unsigned FIELD_W        = 32;
	localparam int unsigned OP_W           = 4;
	// Wide enough for any product sum, difference or quotient before it is clamped.
	localparam int unsigned EXT_W          = 66;
	localparam int unsigned Q_DEPTH        = 2;
	localparam int unsigned Q_PTR_W        = 1;
	localparam int unsigned Q_CNT_W        = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_SCALE = 4'd3,
		OP_DOT   = 4'd4,
		OP_CROSS = 4'd5,
		OP_LEN   = 4'd6,
		OP_LENSQ = 4'd7,
		OP_NORM  = 4'd8,
		OP_SWAP  = 4'd9
	} op_t;

	// Which operand pairs feed the multiplier bank.
	typedef enum logic [1:0] {
		MS_FACTOR = 2'd0,
		MS_B      = 2'd1,
		MS_SELF   = 2'd2,
		MS_CROSS  = 2'd3
	} msel_t;

	typedef struct packed {
		op_t                op;
		msel_t              msel;
		logic [FIELD_W-1:0] ax;
		logic [FIELD_W-1:0] ay;
		logic [FIELD_W-1:0] az;
		logic [FIELD_W-1:0] bx;
		logic [FIELD_W-1:0] by_comp;
		logic [FIELD_W-1:0] bz;
		logic [FIELD_W-1:0] factor;
	} item_t;

	typedef struct packed {
		logic full;
		logic nempty;
	} q_stat_t;

	typedef struct packed {
		logic [FIELD_W-1:0] val;
		logic               ovf;
	} sat_t;

	// Clamps a wide signed value into [lo, hi] and keeps the low field bits.
	function automatic sat_t sat_word(input logic signed [EXT_W-1:0] x,
			input logic signed [EXT_W-1:0] hi, input logic signed [EXT_W-1:0] lo);
		sat_t r;
		r.val = x[FIELD_W-1:0];
		r.ovf = 1'b0;
		if (x > hi) begin
			r.val = hi[FIELD_W-1:0];
			r.ovf = 1'b1;
		end else if (x < lo) begin
			r.val = lo[FIELD_W-1:0];
			r.ovf = 1'b1;
		end
		return r;
	endfunction

endpackage

### src/v3alu_front.sv
module v3alu_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 stall,
	input  logic [v3alu_pkg::OP_W-1:0]           opcode,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] ax,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] ay,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] az,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] bx,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] by_comp,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] bz,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] factor,
	input  v3alu_pkg::q_stat_t                   q_stat,
	output logic                                 push,
	output v3alu_pkg::item_t                     push_item
);

	logic             vld_s1;
	v3alu_pkg::item_t item_s1;
	v3alu_pkg::item_t dec;

	// The beat waits here only while the queue is full.
	assign stall     = vld_s1 && q_stat.full;
	assign push      = vld_s1 && !q_stat.full;
	assign push_item = item_s1;

	always_comb begin
		dec.op      = v3alu_pkg::op_t'(opcode);
		dec.ax      = ax;
		dec.ay      = ay;
		dec.az      = az;
		dec.bx      = bx;
		dec.by_comp = by_comp;
		dec.bz      = bz;
		dec.factor  = factor;
		unique case (v3alu_pkg::op_t'(opcode)) inside
			v3alu_pkg::OP_SCALE: begin
				dec.msel = v3alu_pkg::MS_FACTOR;
			end
			v3alu_pkg::OP_CROSS: begin
				dec.msel = v3alu_pkg::MS_CROSS;
			end
			v3alu_pkg::OP_LEN, v3alu_pkg::OP_LENSQ, v3alu_pkg::OP_NORM: begin
				dec.msel = v3alu_pkg::MS_SELF;
			end
			default: begin
				dec.msel = v3alu_pkg::MS_B;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			item_s1 <= dec;
		end
	end

endmodule

### src/v3alu_fifo.sv
module v3alu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  v3alu_pkg::item_t   push_item,
	input  logic               pop,
	output v3alu_pkg::q_stat_t q_stat,
	output v3alu_pkg::item_t   head_item
);

	v3alu_pkg::item_t                 mem_q [v3alu_pkg::Q_DEPTH];
	logic [v3alu_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [v3alu_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [v3alu_pkg::Q_CNT_W-1:0]    cnt_q;

	assign q_stat.full   = (cnt_q == v3alu_pkg::Q_CNT_W'(v3alu_pkg::Q_DEPTH));
	assign q_stat.nempty = (cnt_q != '0);
	assign head_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/v3alu_back.sv
module v3alu_back #(
	parameter int unsigned FRAC_BITS  = v3alu_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_WIDTH = v3alu_pkg::WORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  v3alu_pkg::q_stat_t                   q_stat,
	input  v3alu_pkg::item_t                     head_item,
	output logic                                 pop,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [v3alu_pkg::FIELD_W-1:0] rx,
	output logic signed [v3alu_pkg::FIELD_W-1:0] ry,
	output logic signed [v3alu_pkg::FIELD_W-1:0] rz,
	output logic signed [v3alu_pkg::FIELD_W-1:0] scalar_out,
	output logic                                 flag
);

	localparam int unsigned FW        = v3alu_pkg::FIELD_W;
	localparam int unsigned XW        = v3alu_pkg::EXT_W;
	localparam int unsigned PW        = 2 * FW;
	localparam int unsigned RAD_W     = 2 * FW;
	localparam int unsigned SQ_STEPS  = FW;
	localparam int unsigned SQ_REM_W  = FW + 4;
	localparam int unsigned DW        = FW + FRAC_BITS;
	localparam int unsigned DIV_REM_W = FW + 1;
	localparam logic signed [XW-1:0] SAT_HI = XW'((XW'(1) << (WORD_WIDTH - 1)) - XW'(1));
	localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic                   vld;
		v3alu_pkg::op_t         op;
		logic [3:0][FW-1:0]     r;
		logic                   flag;
		logic [2:0]             neg;
		logic [2:0][FW-1:0]     mag;
	} carry_t;

	typedef struct packed {
		carry_t                 c;
		logic [RAD_W-1:0]       rad;
		logic [SQ_REM_W-1:0]    rem;
		logic [FW-1:0]          root;
	} sq_t;

	typedef struct packed {
		carry_t                    c;
		logic [FW-1:0]             len;
		logic [2:0][DW-1:0]        dvd;
		logic [2:0][DIV_REM_W-1:0] rem;
		logic [2:0][DW-1:0]        quo;
	} dv_t;

	logic adv;

	logic signed [FW-1:0]  a_v [3];
	logic signed [FW-1:0]  b_v [3];
	logic signed [FW-1:0]  ml [6];
	logic signed [FW-1:0]  mr [6];
	logic signed [XW-1:0]  lin_pre [3];
	v3alu_pkg::sat_t       lin_st [3];
	carry_t                lin_c;

	logic signed [PW-1:0]  prod_s1 [6];
	carry_t                c_s1;

	logic signed [PW-1:0]  sh [6];
	logic signed [XW-1:0]  pre [4];
	logic [RAD_W-1:0]      rad_sum;
	logic signed [XW-1:0]  pre_s2 [4];
	logic [RAD_W-1:0]      rad_s2;
	carry_t                c_s2;

	v3alu_pkg::sat_t       mul_st [4];
	carry_t                mul_c;
	carry_t                c_s3;
	logic [RAD_W-1:0]      rad_s3;

	sq_t                   sq_head;
	sq_t                   sq_s [SQ_STEPS];
	dv_t                   dv_head;
	dv_t                   dv_s [DW];

	dv_t                   fin;
	logic [3:0][FW-1:0]    fin_r;
	logic                  fin_flag;
	v3alu_pkg::sat_t       len_st;
	logic signed [XW-1:0]  qv [3];
	v3alu_pkg::sat_t       q_st [3];

	assign adv = !(res_valid && res_stall);
	assign pop = q_stat.nempty && adv;

	// Stage 1: multiplier bank and the add, subtract, negate and swap results.
	always_comb begin
		a_v[0] = $signed(head_item.ax);
		a_v[1] = $signed(head_item.ay);
		a_v[2] = $signed(head_item.az);
		b_v[0] = $signed(head_item.bx);
		b_v[1] = $signed(head_item.by_comp);
		b_v[2] = $signed(head_item.bz);
		for (int i = 0; i < 6; i++) begin
			ml[i] = '0;
			mr[i] = '0;
		end
		unique case (head_item.msel)
			v3alu_pkg::MS_FACTOR: begin
				for (int i = 0; i < 3; i++) begin
					ml[i] = a_v[i];
					mr[i] = $signed(head_item.factor);
				end
			end
			v3alu_pkg::MS_B: begin
				for (int i = 0; i < 3; i++) begin
					ml[i] = a_v[i];
					mr[i] = b_v[i];
				end
			end
			v3alu_pkg::MS_SELF: begin
				for (int i = 0; i < 3; i++) begin
					ml[i] = a_v[i];
					mr[i] = a_v[i];
				end
			end
			v3alu_pkg::MS_CROSS: begin
				ml[0] = a_v[1]; mr[0] = b_v[2];
				ml[1] = b_v[0]; mr[1] = a_v[2];
				ml[2] = a_v[0]; mr[2] = b_v[1];
				ml[3] = b_v[1]; mr[3] = a_v[2];
				ml[4] = a_v[0]; mr[4] = b_v[2];
				ml[5] = b_v[0]; mr[5] = a_v[1];
			end
		endcase
	end

	always_comb begin
		lin_c     = '0;
		lin_c.vld = pop;
		lin_c.op  = head_item.op;
		for (int i = 0; i < 3; i++) begin
			lin_c.neg[i] = a_v[i][FW-1];
			lin_c.mag[i] = a_v[i][FW-1] ? FW'(~a_v[i] + 1'b1) : FW'(a_v[i]);
			unique case (head_item.op)
				v3alu_pkg::OP_ADD: lin_pre[i] = XW'(a_v[i]) + XW'(b_v[i]);
				v3alu_pkg::OP_SUB: lin_pre[i] = XW'(a_v[i]) - XW'(b_v[i]);
				v3alu_pkg::OP_NEG: lin_pre[i] = -XW'(a_v[i]);
				default:           lin_pre[i] = '0;
			endcase
			lin_st[i]  = v3alu_pkg::sat_word(lin_pre[i], SAT_HI, SAT_LO);
			lin_c.r[i] = lin_st[i].val;
			lin_c.flag = lin_c.flag | lin_st[i].ovf;
		end
		if (head_item.op == v3alu_pkg::OP_SWAP) begin
			lin_c.r[0] = FW'(a_v[0]);
			lin_c.r[1] = FW'(a_v[2]);
			lin_c.r[2] = FW'(a_v[1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
		end else if (adv) begin
			c_s1 <= lin_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				prod_s1[i] <= ml[i] * mr[i];
			end
		end
	end

	// Stage 2: truncate the products and form sums and differences.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			sh[i] = prod_s1[i] >>> FRAC_BITS;
		end
		rad_sum = RAD_W'(prod_s1[0]) + RAD_W'(prod_s1[1]) + RAD_W'(prod_s1[2]);
		for (int i = 0; i < 4; i++) begin
			pre[i] = '0;
		end
		unique case (c_s1.op) inside
			v3alu_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					pre[i] = XW'(sh[i]);
				end
			end
			v3alu_pkg::OP_DOT, v3alu_pkg::OP_LENSQ: begin
				pre[3] = XW'(sh[0]) + XW'(sh[1]) + XW'(sh[2]);
			end
			v3alu_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					pre[i] = XW'(sh[i]) - XW'(sh[i+3]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s2 <= '0;
		end else if (adv) begin
			c_s2 <= c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				pre_s2[i] <= pre[i];
			end
			rad_s2 <= rad_sum;
		end
	end

	// Stage 3: clamp the product results and merge with the linear ones.
	always_comb begin
		mul_c      = c_s2;
		mul_c.flag = 1'b0;
		for (int i = 0; i < 4; i++) begin
			mul_st[i]  = v3alu_pkg::sat_word(pre_s2[i], SAT_HI, SAT_LO);
			mul_c.r[i] = mul_st[i].val;
			mul_c.flag = mul_c.flag | mul_st[i].ovf;
		end
		case (c_s2.op) inside
			v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NEG, v3alu_pkg::OP_SWAP: begin
				mul_c = c_s2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s3 <= '0;
		end else if (adv) begin
			c_s3 <= mul_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= rad_s2;
		end
	end

	// Square root: one result bit per stage over the sum of raw squares.
	always_comb begin
		sq_head      = '0;
		sq_head.c    = c_s3;
		sq_head.rad  = rad_s3;
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		sq_t                 src;
		sq_t                 nxt;
		logic [SQ_REM_W-1:0] rsh;
		logic [SQ_REM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign src = sq_head;
		end else begin : g_next
			assign src = sq_s[k-1];
		end

		assign rsh   = {src.rem[SQ_REM_W-3:0], src.rad[RAD_W-1 -: 2]};
		assign trial = {{(SQ_REM_W-FW-2){1'b0}}, src.root, 2'b01};

		always_comb begin
			nxt     = src;
			nxt.rad = {src.rad[RAD_W-3:0], 2'b00};
			if (rsh >= trial) begin
				nxt.rem  = rsh - trial;
				nxt.root = {src.root[FW-2:0], 1'b1};
			end else begin
				nxt.rem  = rsh;
				nxt.root = {src.root[FW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_s[k] <= '0;
			end else if (adv) begin
				sq_s[k] <= nxt;
			end
		end
	end

	// Normalize: three restoring dividers by the length, one quotient bit per stage.
	always_comb begin
		dv_head     = '0;
		dv_head.c   = sq_s[SQ_STEPS-1].c;
		dv_head.len = sq_s[SQ_STEPS-1].root;
		for (int i = 0; i < 3; i++) begin
			dv_head.dvd[i] = {sq_s[SQ_STEPS-1].c.mag[i], {FRAC_BITS{1'b0}}};
		end
	end

	for (genvar j = 0; j < DW; j++) begin : g_div
		dv_t                       src;
		dv_t                       nxt;
		logic [2:0][DIV_REM_W-1:0] rsh;

		if (j == 0) begin : g_first
			assign src = dv_head;
		end else begin : g_next
			assign src = dv_s[j-1];
		end

		always_comb begin
			nxt = src;
			for (int i = 0; i < 3; i++) begin
				rsh[i]     = {src.rem[i][DIV_REM_W-2:0], src.dvd[i][DW-1]};
				nxt.dvd[i] = {src.dvd[i][DW-2:0], 1'b0};
				if (rsh[i] >= {1'b0, src.len}) begin
					nxt.rem[i] = rsh[i] - {1'b0, src.len};
					nxt.quo[i] = {src.quo[i][DW-2:0], 1'b1};
				end else begin
					nxt.rem[i] = rsh[i];
					nxt.quo[i] = {src.quo[i][DW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= '0;
			end else if (adv) begin
				dv_s[j] <= nxt;
			end
		end
	end

	// Final stage: pick up the length and normalize results.
	always_comb begin
		fin      = dv_s[DW-1];
		fin_r    = fin.c.r;
		fin_flag = fin.c.flag;
		len_st   = v3alu_pkg::sat_word($signed(XW'(fin.len)), SAT_HI, SAT_LO);
		for (int i = 0; i < 3; i++) begin
			qv[i]   = $signed(XW'(fin.quo[i]));
			qv[i]   = fin.c.neg[i] ? -qv[i] : qv[i];
			q_st[i] = v3alu_pkg::sat_word(qv[i], SAT_HI, SAT_LO);
		end
		if (fin.c.op == v3alu_pkg::OP_LEN) begin
			fin_r[3] = len_st.val;
			fin_flag = len_st.ovf;
		end else if (fin.c.op == v3alu_pkg::OP_NORM) begin
			fin_r = '0;
			if (fin.len == '0) begin
				fin_flag = 1'b1;
			end else begin
				fin_flag = 1'b0;
				for (int i = 0; i < 3; i++) begin
					fin_r[i] = q_st[i].val;
					fin_flag = fin_flag | q_st[i].ovf;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= fin.c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx         <= $signed(fin_r[0]);
			ry         <= $signed(fin_r[1]);
			rz         <= $signed(fin_r[2]);
			scalar_out <= $signed(fin_r[3]);
			flag       <= fin_flag;
		end
	end

endmodule

### src/vector3_alu_unit.sv
// Stateless 3D vector unit in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default). Each input beat carries an opcode, vectors a and b and a scale factor; each
// produces exactly one result beat holding a vector (rx, ry, rz) or a scalar
// (scalar_out) plus a flag that marks saturation or normalizing a zero vector. The unit
// takes one beat per clock while the queue has room; it raises stall while the queue is
// full. A front register and a two-entry queue sit ahead of a fully pipelined back end,
// so input and output stall independently. A beat passes through the front register,
// the queue, the multiplier bank, the product sums and the clamping stage, the
// bit-per-stage square root, the bit-per-stage dividers used by normalize, and the
// output register. A stalled result freezes the back end and adds its stall cycles to
// the latency. Every operation walks the whole pipe so results leave in order. Products
// are truncated toward minus infinity, length is the floored square root, and results
// clamp to a signed WORD_WIDTH-bit range before being placed on the 32-bit result ports.
module vector3_alu_unit #(
	parameter int unsigned FRAC_BITS  = v3alu_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_WIDTH = v3alu_pkg::WORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 stall,
	input  logic [v3alu_pkg::OP_W-1:0]           opcode,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] ax,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] ay,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] az,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] bx,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] by_comp,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] bz,
	input  logic signed [v3alu_pkg::FIELD_W-1:0] factor,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [v3alu_pkg::FIELD_W-1:0] rx,
	output logic signed [v3alu_pkg::FIELD_W-1:0] ry,
	output logic signed [v3alu_pkg::FIELD_W-1:0] rz,
	output logic signed [v3alu_pkg::FIELD_W-1:0] scalar_out,
	output logic                                 flag
);

	// Queue handshake between the front and the back end.
	v3alu_pkg::q_stat_t q_stat;
	v3alu_pkg::item_t   push_item;
	v3alu_pkg::item_t   head_item;
	logic               push;
	logic               pop;

	// The front registers the beat and decodes which operand pairs the
	// multipliers will need; it holds the beat only while the queue is full.
	v3alu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.opcode    (opcode),
		.ax        (ax),
		.ay        (ay),
		.az        (az),
		.bx        (bx),
		.by_comp   (by_comp),
		.bz        (bz),
		.factor    (factor),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	v3alu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_stat    (q_stat),
		.head_item (head_item)
	);

	// The back end advances as a whole whenever its output register is free or
	// being taken, so a stalled result freezes the pipe without losing beats.
	v3alu_back #(
		.FRAC_BITS  (FRAC_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_item  (head_item),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.rx         (rx),
		.ry         (ry),
		.rz         (rz),
		.scalar_out (scalar_out),
		.flag       (flag)
	);

	// The front must never write into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_stat.full))
		else $error("queue written while full");

	// A full queue has to report entries available to the back end.
	assert property (@(posedge clk) disable iff (!arst_n) q_stat.full |-> q_stat.nempty)
		else $error("queue status inconsistent");

	// A write with no read leaves at least one entry behind.
	assert property (@(posedge clk) disable iff (!arst_n) (push && !pop) |=> q_stat.nempty)
		else $error("queue lost an entry");

endmodule
